[rtl/tstp_pkg.sv]
// ----------------------------------------------------------------------------
// tstp_pkg
// Shared types and codes for the task slot table: request opcodes, status
// codes and the request payload that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package tstp_pkg;

  localparam int OP_W     = 2;
  localparam int PARENT_W = 17;
  localparam int PRIO_W   = 5;
  localparam int ADDR_W   = 32;

  localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
  localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic signed [PARENT_W-1:0] parent;
    logic [PRIO_W-1:0]          prio;
    logic [ADDR_W-1:0]          start_addr;
  } ent_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    ent_t            ent;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

endpackage

[rtl/tstp_queue.sv]
// ----------------------------------------------------------------------------
// tstp_queue
// Two-entry request queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tstp_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  logic [W-1:0] fifo_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[rtl/tstp_front.sv]
// ----------------------------------------------------------------------------
// tstp_front
// Request front end: takes a beat, reduces the identifier modulo the table
// depth by a reciprocal multiply for destroy and lookup, and queues the request.
// ----------------------------------------------------------------------------
module tstp_front
  import tstp_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int ID_WIDTH    = 16,
  localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [OP_W-1:0]            in_op,
  input  logic [ID_WIDTH-1:0]        in_task_id,
  input  logic signed [PARENT_W-1:0] in_parent_id,
  input  logic [PRIO_W-1:0]          in_priority_in,
  input  logic [ADDR_W-1:0]          in_start_address,
  input  logic                       q_full,
  output logic                       q_push,
  output logic [IDX_W-1:0]           q_idx,
  output logic [ID_WIDTH-1:0]        q_id,
  output cmd_t                       q_cmd
);

  localparam int SH     = ID_WIDTH + IDX_W;
  localparam int RCP_W  = ID_WIDTH + 2;
  localparam int PROD_W = ID_WIDTH + RCP_W + IDX_W;

  // ceil(2^SH / TABLE_DEPTH), exact quotient for every identifier
  localparam logic [RCP_W-1:0] RCP = RCP_W'(((64'd1 << SH) + 64'(TABLE_DEPTH) - 64'd1)
                                            / 64'(TABLE_DEPTH));
  localparam logic [IDX_W-1:0] DEPTH_LO = IDX_W'(TABLE_DEPTH);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MOD  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;
  localparam logic [1:0] F_REM  = 2'd3;

  logic [1:0]          state_r;
  cmd_t                cmd_r;
  logic [ID_WIDTH-1:0] id_r;
  logic [IDX_W-1:0]    quot_r;
  logic [IDX_W-1:0]    rem_r;
  logic [PROD_W-1:0]   prod;
  logic                accept;

  assign busy   = (state_r != F_IDLE);
  assign accept = start && !busy;
  assign q_push = (state_r == F_PUSH) && !q_full;
  assign q_idx  = rem_r;
  assign q_id   = id_r;
  assign q_cmd  = cmd_r;

  // low bits of the quotient are all the remainder needs
  assign prod = PROD_W'(id_r) * PROD_W'(RCP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            if (in_op == OP_DESTROY || in_op == OP_LOOKUP) begin
              state_r <= F_MOD;
            end else begin
              state_r <= F_PUSH;
            end
          end
        end
        F_MOD: begin
          state_r <= F_REM;
        end
        F_REM: begin
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.op             <= in_op;
      cmd_r.ent.parent     <= in_parent_id;
      cmd_r.ent.prio       <= in_priority_in;
      cmd_r.ent.start_addr <= in_start_address;
      id_r                 <= in_task_id;
      rem_r                <= '0;
    end else if (state_r == F_MOD) begin
      quot_r <= prod[SH +: IDX_W];
    end else if (state_r == F_REM) begin
      rem_r <= IDX_W'(id_r) - IDX_W'(quot_r * DEPTH_LO);
    end
  end

endmodule

[rtl/tstp_back.sv]
// ----------------------------------------------------------------------------
// tstp_back
// Table back end: owns the slot memory, live bits and identifier counter,
// walks the probe sequence and drives one result beat per request.
// ----------------------------------------------------------------------------
module tstp_back
  import tstp_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int ID_WIDTH    = 16,
  localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  logic [IDX_W-1:0]           q_idx,
  input  logic [ID_WIDTH-1:0]        q_id,
  input  cmd_t                       q_cmd,
  output logic                       out_valid,
  output logic                       out_status,
  output logic [IDX_W-1:0]           out_slot,
  output logic [ID_WIDTH-1:0]        out_task_id_out,
  output logic signed [PARENT_W-1:0] out_parent_id_out,
  output logic [PRIO_W-1:0]          out_priority_out,
  output logic [ADDR_W-1:0]          out_start_address_out
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_FREE = 2'd1;
  localparam logic [1:0] B_LIVE = 2'd2;

  logic [1:0]             state_r;
  logic [OP_W-1:0]        op_r;
  logic [ID_WIDTH-1:0]    id_r;
  ent_t                   ent_r;
  logic [IDX_W-1:0]       pidx_r;
  logic [CNT_W-1:0]       icnt_r;
  logic                   rd_vld_r;
  logic [IDX_W-1:0]       rd_addr_r;
  logic [TABLE_DEPTH-1:0] live_r;
  logic [ID_WIDTH-1:0]    next_id_r;
  logic [IDX_W-1:0]       next_idx_r;

  logic [ID_WIDTH-1:0]    mem_id  [TABLE_DEPTH];
  ent_t                   mem_ent [TABLE_DEPTH];
  logic [ID_WIDTH-1:0]    rd_id_r;
  ent_t                   rd_ent_r;

  logic                   out_valid_r;
  logic                   out_status_r;
  logic [IDX_W-1:0]       out_slot_r;
  logic [ID_WIDTH-1:0]    out_id_r;
  ent_t                   out_ent_r;

  logic [IDX_W-1:0]       pidx_inc;
  logic [IDX_W-1:0]       nidx_inc;
  logic                   free_hit;
  logic                   free_last;
  logic                   rd_en;
  logic                   wr_en;
  logic                   live_hit;
  logic                   live_miss;
  logic                   bad_op;

  assign pidx_inc  = (pidx_r == IDX_W'(TABLE_DEPTH - 1)) ? '0 : pidx_r + 1'b1;
  assign nidx_inc  = (next_idx_r == IDX_W'(TABLE_DEPTH - 1)) ? '0 : next_idx_r + 1'b1;
  assign free_hit  = (state_r == B_FREE) && !live_r[pidx_r];
  assign free_last = (state_r == B_FREE) && (icnt_r == CNT_W'(TABLE_DEPTH - 1));
  assign wr_en     = free_hit;
  assign rd_en     = (state_r == B_LIVE) && (icnt_r != CNT_W'(TABLE_DEPTH));
  assign live_hit  = (state_r == B_LIVE) && rd_vld_r && live_r[rd_addr_r]
                     && (rd_id_r == id_r);
  assign live_miss = (state_r == B_LIVE) && !rd_vld_r
                     && (icnt_r == CNT_W'(TABLE_DEPTH));
  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign bad_op    = (q_cmd.op != OP_CREATE) && (q_cmd.op != OP_DESTROY)
                     && (q_cmd.op != OP_LOOKUP);

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_slot              = out_slot_r;
  assign out_task_id_out       = out_id_r;
  assign out_parent_id_out     = out_ent_r.parent;
  assign out_priority_out      = out_ent_r.prio;
  assign out_start_address_out = out_ent_r.start_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      live_r      <= '0;
      next_id_r   <= ID_WIDTH'(1);
      next_idx_r  <= IDX_W'(1);
    end else begin
      out_valid_r <= 1'b0;
      rd_vld_r    <= rd_en;
      unique case (state_r)
        B_IDLE: begin
          if (q_pop) begin
            if (q_cmd.op == OP_CREATE) begin
              state_r <= B_FREE;
            end else if (!bad_op) begin
              state_r <= B_LIVE;
            end else begin
              out_valid_r <= 1'b1;
            end
          end
        end
        B_FREE: begin
          if (free_hit) begin
            live_r[pidx_r] <= 1'b1;
            next_id_r      <= next_id_r + 1'b1;
            next_idx_r     <= (next_id_r == '1) ? '0 : nidx_inc;
            out_valid_r    <= 1'b1;
            state_r        <= B_IDLE;
          end else if (free_last) begin
            out_valid_r <= 1'b1;
            state_r     <= B_IDLE;
          end
        end
        B_LIVE: begin
          if (live_hit) begin
            if (op_r == OP_DESTROY) begin
              live_r[rd_addr_r] <= 1'b0;
            end
            out_valid_r <= 1'b1;
            state_r     <= B_IDLE;
          end else if (live_miss) begin
            out_valid_r <= 1'b1;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // probe walk and result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r   <= q_cmd.op;
      id_r   <= q_id;
      ent_r  <= q_cmd.ent;
      pidx_r <= (q_cmd.op == OP_CREATE) ? next_idx_r : q_idx;
      icnt_r <= '0;
    end else if ((state_r == B_FREE) && !free_hit) begin
      pidx_r <= pidx_inc;
      icnt_r <= icnt_r + 1'b1;
    end else if (rd_en) begin
      rd_addr_r <= pidx_r;
      pidx_r    <= pidx_inc;
      icnt_r    <= icnt_r + 1'b1;
    end

    if (free_hit) begin
      out_status_r <= STATUS_OK;
      out_slot_r   <= pidx_r;
      out_id_r     <= next_id_r;
      out_ent_r    <= ent_r;
    end else if (live_hit) begin
      out_status_r <= STATUS_OK;
      out_slot_r   <= rd_addr_r;
      out_id_r     <= rd_id_r;
      out_ent_r    <= rd_ent_r;
    end else if ((q_pop && bad_op) || free_last || live_miss) begin
      out_status_r <= STATUS_FAIL;
      out_slot_r   <= '0;
      out_id_r     <= '0;
      out_ent_r    <= '0;
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[pidx_r]  <= next_id_r;
      mem_ent[pidx_r] <= ent_r;
    end
    if (rd_en) begin
      rd_id_r  <= mem_id[pidx_r];
      rd_ent_r <= mem_ent[pidx_r];
    end
  end

endmodule

[rtl/task_slot_table_probe.sv]
// ----------------------------------------------------------------------------
// task_slot_table_probe
// Task slot table with linear probing: create, destroy and lookup requests
// against TABLE_DEPTH slots with a wrapping identifier counter.
// ----------------------------------------------------------------------------
// Create goes straight from the front end to the queue; destroy and lookup
// first pass the home slot reduction in the front end (F_MOD, then F_REM). The
// back end then walks the probe sequence at one slot per cycle until a hit or
// until every slot is probed. The back end works on one request at a time, and
// the front end takes a new beat only while busy is low.
// Reset: synchronous, clears all live bits and sets the identifier counter to 1.
// ----------------------------------------------------------------------------
module task_slot_table_probe
  import tstp_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int ID_WIDTH    = 16,
  localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [OP_W-1:0]            in_op,
  input  logic [ID_WIDTH-1:0]        in_task_id,
  input  logic signed [PARENT_W-1:0] in_parent_id,
  input  logic [PRIO_W-1:0]          in_priority_in,
  input  logic [ADDR_W-1:0]          in_start_address,
  output logic                       out_valid,
  output logic                       out_status,
  output logic [IDX_W-1:0]           out_slot,
  output logic [ID_WIDTH-1:0]        out_task_id_out,
  output logic signed [PARENT_W-1:0] out_parent_id_out,
  output logic [PRIO_W-1:0]          out_priority_out,
  output logic [ADDR_W-1:0]          out_start_address_out
);

  localparam int QW = IDX_W + ID_WIDTH + CMD_W;

  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;
  logic [IDX_W-1:0]    f_idx;
  logic [ID_WIDTH-1:0] f_id;
  cmd_t                f_cmd;
  logic [QW-1:0]       q_wr_data;
  logic [QW-1:0]       q_rd_data;
  logic [IDX_W-1:0]    b_idx;
  logic [ID_WIDTH-1:0] b_id;
  cmd_t                b_cmd;

  assign q_wr_data = {f_idx, f_id, f_cmd};
  assign b_cmd     = cmd_t'(q_rd_data[CMD_W-1:0]);
  assign b_id      = q_rd_data[CMD_W +: ID_WIDTH];
  assign b_idx     = q_rd_data[CMD_W+ID_WIDTH +: IDX_W];

  tstp_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_task_id       (in_task_id),
    .in_parent_id     (in_parent_id),
    .in_priority_in   (in_priority_in),
    .in_start_address (in_start_address),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_idx            (f_idx),
    .q_id             (f_id),
    .q_cmd            (f_cmd)
  );

  tstp_queue #(
    .W (QW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  tstp_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_empty               (q_empty),
    .q_pop                 (q_pop),
    .q_idx                 (b_idx),
    .q_id                  (b_id),
    .q_cmd                 (b_cmd),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_slot              (out_slot),
    .out_task_id_out       (out_task_id_out),
    .out_parent_id_out     (out_parent_id_out),
    .out_priority_out      (out_priority_out),
    .out_start_address_out (out_start_address_out)
  );

endmodule
